FILE: hw/rtl/master_stack_tile_layout_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the master/stack tile layout block
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MASTER_STACK_TILE_LAYOUT_MACROS_SVH
`define MASTER_STACK_TILE_LAYOUT_MACROS_SVH

// Same-cycle implication.
`define MSTL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mstl assertion failed");

// Next-cycle implication.
`define MSTL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mstl assertion failed");

`endif

FILE: hw/rtl/mstl_pkg.sv
// ----------------------------------------------------------------------------
// mstl_pkg
// Shared types and constants for the master/stack tile layout block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mstl_pkg;

    localparam int MAX_WINDOWS_DEF = 32;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 5;
    localparam int IW         = 20;   // internal coordinate width, signed
    localparam int NW         = 18;   // height numerator width, signed
    localparam int RW         = CNT_W + 1;
    localparam int STEP_W     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AREA_X          = 3'd0,
        REG_AREA_Y          = 3'd1,
        REG_AREA_WIDTH      = 3'd2,
        REG_AREA_HEIGHT     = 3'd3,
        REG_GAP_SIZES       = 3'd4,
        REG_MASTER_COUNT    = 3'd5,
        REG_MASTER_FRACTION = 3'd6,
        REG_LAYOUT_FLAGS    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic calc_mw;
        logic col_init;
        logic div_start;
        logic div_step;
        logic emit;
    } mstl_cmd_t;

    typedef struct packed {
        logic zero_count;
        logic div_done;
        logic out_free;
        logic last;
        logic next_col;
    } mstl_stat_t;

endpackage

FILE: hw/rtl/mstl_ctrl.sv
// ----------------------------------------------------------------------------
// mstl_ctrl
// Sequencer: walks one request through setup, per-column init, divide, emit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mstl_pkg::mstl_stat_t stat,
    output mstl_pkg::mstl_cmd_t  cmd
);
    import mstl_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_COLI = 7'b0000100,
        ST_DIVS = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_EMIT = 7'b0100000,
        ST_MW   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = stat.zero_count ? ST_IDLE : ST_MW;
            end
            ST_MW:
            begin
                cmd.calc_mw = 1'b1;
                state_next  = ST_COLI;
            end
            ST_COLI:
            begin
                cmd.col_init = 1'b1;
                state_next   = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.next_col)
                    begin
                        state_next = ST_COLI;
                    end
                    else
                    begin
                        state_next = ST_DIVS;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/mstl_datapath.sv
// ----------------------------------------------------------------------------
// mstl_datapath
// Configuration registers, master width, column cursors, bit-serial divider
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstl_datapath
#(
    parameter int MAX_WINDOWS = mstl_pkg::MAX_WINDOWS_DEF,
    parameter int COORD_WIDTH = mstl_pkg::COORD_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mstl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mstl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [mstl_pkg::CNT_W-1:0]         window_count,
    input  mstl_pkg::mstl_cmd_t                cmd,
    output mstl_pkg::mstl_stat_t               stat,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mstl_pkg::IDX_W-1:0]         window_index,
    output logic signed [COORD_WIDTH-1:0]      win_x,
    output logic signed [COORD_WIDTH-1:0]      win_y,
    output logic signed [COORD_WIDTH-1:0]      win_w,
    output logic signed [COORD_WIDTH-1:0]      win_h,
    output logic                               last_window
);
    import mstl_pkg::*;

    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (COORD_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [IW-1:0] v);
        logic signed [33:0] e;
        e = 34'(v);
        if (e > SAT_HI)
        begin
            e = SAT_HI;
        end
        else if (e < SAT_LO)
        begin
            e = SAT_LO;
        end
        return e[COORD_WIDTH-1:0];
    endfunction

    // configuration
    logic signed [15:0] area_x_reg, area_y_reg;
    logic [14:0]        area_w_reg, area_h_reg;
    logic [31:0]        gaps_reg;
    logic [7:0]         mcount_reg;
    logic [15:0]        frac_reg;
    logic [1:0]         flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_x_reg <= '0;
            area_y_reg <= '0;
            area_w_reg <= 15'd1920;
            area_h_reg <= 15'd1080;
            gaps_reg   <= '0;
            mcount_reg <= 8'd1;
            frac_reg   <= 16'd36045;
            flags_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AREA_X:          area_x_reg <= cfg_data[15:0];
                REG_AREA_Y:          area_y_reg <= cfg_data[15:0];
                REG_AREA_WIDTH:      area_w_reg <= cfg_data[14:0];
                REG_AREA_HEIGHT:     area_h_reg <= cfg_data[14:0];
                REG_GAP_SIZES:       gaps_reg   <= cfg_data;
                REG_MASTER_COUNT:    mcount_reg <= cfg_data[7:0];
                REG_MASTER_FRACTION: frac_reg   <= cfg_data[15:0];
                REG_LAYOUT_FLAGS:    flags_reg  <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // per-request working registers
    logic [CNT_W-1:0]     cnt_reg, nm_reg, i_reg, r_reg;
    logic [7:0]           goh_reg, gov_reg, gih_reg, giv_reg;
    logic [31:0]          prod_reg;
    logic signed [NW-1:0] num_reg;
    logic signed [IW-1:0] c_reg;
    logic                 neg_reg;
    logic [NW-1:0]        quo_reg;
    logic [RW-1:0]        rem_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 out_valid_reg;

    logic [CNT_W-1:0] cnt_sat;
    logic             smart;
    logic             in_master;
    logic             stack_any;
    logic [CNT_W-1:0] r_col;
    logic [13:0]      gap_mul;
    logic [RW-1:0]    trial;
    logic signed [IW-1:0] mw, h_ext, x_val, y_val, w_val;
    logic signed [NW-1:0] h_val;
    logic signed [IW-1:0] ax, aw, gohx, gihx, govx, givx;

    assign cnt_sat = ({1'b0, window_count} > 7'(MAX_WINDOWS)) ?
                     CNT_W'(MAX_WINDOWS) : window_count;
    assign smart   = flags_reg[0] && (cnt_sat == CNT_W'(1));

    assign in_master = (i_reg < nm_reg);
    assign stack_any = (cnt_reg > nm_reg);
    assign r_col     = in_master ? (nm_reg - i_reg) : (cnt_reg - i_reg);
    assign gap_mul   = giv_reg * 6'(r_col - CNT_W'(1));

    assign ax   = IW'(area_x_reg);
    assign aw   = $signed({{(IW-15){1'b0}}, area_w_reg});
    assign gohx = $signed({{(IW-8){1'b0}}, goh_reg});
    assign gihx = $signed({{(IW-8){1'b0}}, gih_reg});
    assign govx = $signed({{(IW-8){1'b0}}, gov_reg});
    assign givx = $signed({{(IW-8){1'b0}}, giv_reg});

    always_comb
    begin
        if (!stack_any)
        begin
            mw = aw - (gohx <<< 1) + gihx;
        end
        else if (nm_reg == '0)
        begin
            mw = '0;
        end
        else
        begin
            mw = $signed({{(IW-16){1'b0}}, prod_reg[31:16]});
        end
    end

    assign trial = {rem_reg[RW-2:0], quo_reg[NW-1]} - {1'b0, r_reg};
    assign h_val = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign h_ext = IW'(h_val);
    assign y_val = IW'(area_y_reg) + c_reg;

    always_comb
    begin
        if (in_master)
        begin
            x_val = flags_reg[1] ? (ax + aw - mw - gohx + gihx) : (ax + gohx);
            w_val = mw - gihx;
        end
        else
        begin
            x_val = flags_reg[1] ? (ax + gohx) : (ax + mw + gohx);
            w_val = aw - mw - (gohx <<< 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg <= cnt_sat;
            i_reg   <= '0;
            goh_reg <= smart ? 8'd0 : gaps_reg[7:0];
            gov_reg <= smart ? 8'd0 : gaps_reg[15:8];
            gih_reg <= smart ? 8'd0 : gaps_reg[23:16];
            giv_reg <= smart ? 8'd0 : gaps_reg[31:24];
            nm_reg  <= ({1'b0, mcount_reg} < {3'b0, cnt_sat}) ? mcount_reg[CNT_W-1:0] : cnt_sat;
        end
        if (cmd.calc_mw)
        begin
            prod_reg <= ({1'b0, area_w_reg} + {8'b0, gih_reg}) * frac_reg;
        end
        if (cmd.col_init)
        begin
            r_reg   <= r_col;
            num_reg <= $signed({3'b0, area_h_reg}) - $signed({9'b0, gov_reg, 1'b0})
                       - $signed({4'b0, gap_mul});
            c_reg   <= govx;
        end
        if (cmd.div_start)
        begin
            neg_reg  <= num_reg[NW-1];
            quo_reg  <= num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (cmd.div_step)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (!trial[RW-1])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[RW-2:0], quo_reg[NW-1]};
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            window_index <= i_reg[IDX_W-1:0];
            win_x        <= sat_coord(x_val);
            win_y        <= sat_coord(y_val);
            win_w        <= sat_coord(w_val);
            win_h        <= sat_coord(h_ext);
            last_window  <= (i_reg == cnt_reg - CNT_W'(1));
            num_reg      <= num_reg - h_val;
            c_reg        <= c_reg + h_ext + givx;
            r_reg        <= r_reg - CNT_W'(1);
            i_reg        <= i_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stat.zero_count = (cnt_reg == '0);
    assign stat.div_done   = (step_reg == STEP_W'(NW - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.last       = (i_reg == cnt_reg - CNT_W'(1));
    assign stat.next_col   = (i_reg + CNT_W'(1) == nm_reg);

endmodule

FILE: hw/rtl/master_stack_tile_layout.sv
// Master/stack tile layout.
// Input channel (in_valid/in_ready, window_count) takes one request; the block
// answers with one rectangle per window on the output channel (out_valid/
// out_ready), in window order, last_window marking the final one. A count of
// zero gives no rectangles; counts above MAX_WINDOWS are clamped.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle;
// the block itself does not enforce that, the user must. Sequence: setup
// (load, master width), then a column start for each column, and for each
// window a divide start, the restoring divider at one quotient bit per cycle,
// then emit. in_ready is high only
// while no request is in progress. A result sits in the output register until
// taken; while the receiver stalls, the next window's divide proceeds and then
// waits. Reset returns the sequencer to idle, drops any pending result and
// restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// master_stack_tile_layout
// Top level: sequencer plus datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "master_stack_tile_layout_macros.svh"

module master_stack_tile_layout
#(
    parameter int MAX_WINDOWS = mstl_pkg::MAX_WINDOWS_DEF,
    parameter int COORD_WIDTH = mstl_pkg::COORD_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mstl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mstl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mstl_pkg::CNT_W-1:0]      window_count,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mstl_pkg::IDX_W-1:0]      window_index,
    output logic signed [COORD_WIDTH-1:0]   win_x,
    output logic signed [COORD_WIDTH-1:0]   win_y,
    output logic signed [COORD_WIDTH-1:0]   win_w,
    output logic signed [COORD_WIDTH-1:0]   win_h,
    output logic                            last_window
);
    import mstl_pkg::*;

    mstl_cmd_t  cmd;
    mstl_stat_t stat;

    mstl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mstl_datapath
    #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .COORD_WIDTH (COORD_WIDTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .window_count (window_count),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_index (window_index),
        .win_x        (win_x),
        .win_y        (win_y),
        .win_w        (win_w),
        .win_h        (win_h),
        .last_window  (last_window)
    );

    // a new result never overwrites one still waiting
    `MSTL_ASSERT_IMP(a_emit_free, cmd.emit, (!out_valid || out_ready))
    // an accepted request leaves the sequencer busy
    `MSTL_ASSERT_NXT(a_busy_after_accept, (in_valid && in_ready), !in_ready)
    // only one datapath step at a time
    `MSTL_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(cmd))

endmodule
